// ----- rtl/core/rwm_pkg.sv -----
// Package for the rotation window match counter.
// Holds command codes, the controller command and status structs and fixed widths.
// No dependencies.
package rwm_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned CFG_W   = 7;
  localparam int unsigned COUNT_W = 32;

  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t CMD_LOAD  = 2'd0;
  localparam cmd_t CMD_TEXT  = 2'd1;
  localparam cmd_t CMD_CLEAR = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic latch;    // capture the accepted item
    logic cnt_clr;  // zero the scan counter
    logic cnt_inc;  // advance the scan counter
    logic m_rd;     // read pattern entry at the counter
    logic p_rd;     // read progress row at the counter
    logic p_wr;     // update progress row at the counter
    logic fin;      // write result, apply load, clear and count
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_text;
    logic cnt_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- rtl/core/rwm_ifs.sv -----
// Channel interfaces for the rotation window match counter.
// Depends on rwm_pkg for field widths.
interface rwm_in_if;
  logic                      valid;
  logic                      ready;
  logic [rwm_pkg::CMD_W-1:0] command;
  logic [rwm_pkg::SYM_W-1:0] symbol;
  logic                      text_end;
  modport source (output valid, command, symbol, text_end, input ready);
  modport sink   (input valid, command, symbol, text_end, output ready);
endinterface

interface rwm_out_if;
  logic                        valid;
  logic                        ready;
  logic                        window_match;
  logic [rwm_pkg::COUNT_W-1:0] match_count;
  logic                        stream_done;
  modport source (output valid, window_match, match_count, stream_done, input ready);
  modport sink   (input valid, window_match, match_count, stream_done, output ready);
endinterface

// ----- rtl/core/rwm_ctrl.sv -----
// Controller state machine of the rotation window match counter.
// Depends on rwm_pkg for the command and status structs.
module rwm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rwm_pkg::dp_stat_t stat,
  output rwm_pkg::ctrl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MSCAN = 3'd1;
  localparam logic [2:0] S_MDRN  = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_WR    = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch   = 1'b1;
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_FIN;
        end
      end
      S_MSCAN: begin
        cmd.m_rd    = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (stat.cnt_last) state_nxt = S_MDRN;
      end
      S_MDRN: begin
        cmd.cnt_clr = 1'b1;
        state_nxt   = S_RD;
      end
      S_RD: begin
        cmd.p_rd  = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        cmd.p_wr    = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_nxt   = stat.cnt_last ? S_FIN : S_RD;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // text items scan first; others go straight to finish
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else if (state_r == S_IDLE && in_valid) begin
      state_r <= stat.is_text ? S_MSCAN : S_FIN;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/core/rwm_dp.sv -----
// Datapath of the rotation window match counter: pattern store, progress rows,
// rotation compare vector, count and result register. Depends on rwm_pkg.
module rwm_dp #(
  parameter int unsigned MAX_PATTERN = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rwm_pkg::ctrl_cmd_t          cmd,
  output rwm_pkg::dp_stat_t           stat,
  input  logic                        cfg_we,
  input  logic [rwm_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic [rwm_pkg::CMD_W-1:0]   in_command,
  input  logic [rwm_pkg::SYM_W-1:0]   in_symbol,
  input  logic                        in_text_end,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_window_match,
  output logic [rwm_pkg::COUNT_W-1:0] out_match_count,
  output logic                        out_stream_done
);

  localparam int unsigned CW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned AW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [CW-1:0] MAXV = CW'(MAX_PATTERN);
  localparam logic [rwm_pkg::COUNT_W-1:0] CNT_MAX = '1;

  logic [rwm_pkg::CFG_W-1:0]   cfg_r;
  logic [CW-1:0]               len;
  logic [CW-1:0]               len_m1;
  logic [MAX_PATTERN-1:0]      lenmask;
  rwm_pkg::cmd_t               cmd_r;
  logic [rwm_pkg::SYM_W-1:0]   sym_r;
  logic                        end_r;
  logic [CW-1:0]               cnt_r;
  logic [CW-1:0]               lp_r;
  logic [rwm_pkg::SYM_W-1:0]   pat_mem [MAX_PATTERN];
  logic [rwm_pkg::SYM_W-1:0]   pat_q;
  logic                        rdv_r;
  logic [AW-1:0]               jq_r;
  logic [MAX_PATTERN-1:0]      eq_r;
  logic [MAX_PATTERN-1:0]      eq_rot;
  logic [MAX_PATTERN-1:0]      prog_mem [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]      prog_q;
  logic                        pvq_r;
  logic [MAX_PATTERN-1:0]      pv_r;
  logic [MAX_PATTERN-1:0]      prog_new;
  logic                        hit_r;
  logic [rwm_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic                        out_valid_r;
  logic                        om_r, od_r;
  logic                        is_text;

  // effective length, clamped to 1..MAX_PATTERN
  always_comb begin
    if (cfg_r == '0) begin
      len = CW'(1);
    end else if ({1'b0, cfg_r} > 8'(MAX_PATTERN)) begin
      len = MAXV;
    end else begin
      len = CW'(cfg_r);
    end
  end
  assign len_m1 = len - CW'(1);

  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      lenmask[k] = (CW'(k) < len);
      eq_rot[k]  = (CW'(k) == len_m1) ? eq_r[0]
                 : ((k + 1 < MAX_PATTERN) ? eq_r[(k + 1) % MAX_PATTERN] : 1'b0);
    end
  end

  assign is_text = (cmd_r == rwm_pkg::CMD_TEXT);
  assign stat.is_text  = (in_command == rwm_pkg::CMD_TEXT);
  assign stat.cnt_last = (cnt_r == len_m1);
  assign stat.out_free = !out_valid_r || out_ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= rwm_pkg::CFG_W'(1);
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  // captured item
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r <= in_command;
      sym_r <= in_symbol;
      end_r <= in_text_end;
    end
  end

  // scan counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + CW'(1);
    end
  end

  // pattern store: load write at finish, scan read at the counter
  always_ff @(posedge clk) begin
    if (cmd.fin && cmd_r == rwm_pkg::CMD_LOAD && lp_r < MAXV) begin
      pat_mem[lp_r[AW-1:0]] <= sym_r;
    end
    if (cmd.m_rd) begin
      pat_q <= pat_mem[cnt_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdv_r <= 1'b0;
    end else begin
      rdv_r <= cmd.m_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.m_rd) jq_r <= cnt_r[AW-1:0];
  end

  // compare vector: built during the pattern scan, rotated once per row
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      eq_r <= '0;
    end else if (rdv_r) begin
      eq_r[jq_r] <= (pat_q == sym_r);
    end else if (cmd.p_wr) begin
      eq_r <= eq_rot;
    end
  end

  // progress rows
  always_ff @(posedge clk) begin
    if (cmd.p_rd) begin
      prog_q <= prog_mem[cnt_r[AW-1:0]];
      pvq_r  <= pv_r[cnt_r[AW-1:0]];
    end
    if (cmd.p_wr) begin
      prog_mem[cnt_r[AW-1:0]] <= prog_new;
    end
  end

  assign prog_new = (((pvq_r ? prog_q : '0) << 1) | MAX_PATTERN'(1)) & eq_r & lenmask;

  // row valid bits: rows at or above the length read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else if (cmd.fin && cmd_r == rwm_pkg::CMD_CLEAR) begin
      pv_r <= '0;
    end else if (cmd.latch && in_command == rwm_pkg::CMD_TEXT) begin
      pv_r <= pv_r & lenmask;
    end else if (cmd.p_wr) begin
      pv_r[cnt_r[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      hit_r <= 1'b0;
    end else if (cmd.p_wr && prog_new[len_m1[AW-1:0]]) begin
      hit_r <= 1'b1;
    end
  end

  // count update
  always_comb begin
    count_nxt = count_r;
    if (cmd_r == rwm_pkg::CMD_CLEAR) begin
      count_nxt = '0;
    end else if (is_text && hit_r && count_r != CNT_MAX) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      lp_r    <= '0;
    end else if (cmd.fin) begin
      count_r <= count_nxt;
      if (cmd_r == rwm_pkg::CMD_CLEAR) begin
        lp_r <= '0;
      end else if (cmd_r == rwm_pkg::CMD_LOAD && lp_r < MAXV) begin
        lp_r <= lp_r + CW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      om_r <= is_text && hit_r;
      od_r <= is_text && end_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_window_match = om_r;
  assign out_match_count  = count_r;
  assign out_stream_done  = od_r;

endmodule

// ----- rtl/core/rotation_window_match_counter.sv -----
// Top level of the rotation window match counter.
// Depends on rwm_pkg, rwm_ifs, rwm_ctrl and rwm_dp.
//
// Usage: write pattern_length on cfg_we/cfg_wdata while idle, send load items
// (command 0) to fill the pattern, then text items (command 1). Command 2 clears
// the count, the rotation progress and the load pointer. Every item gives one
// result item on out_ch: window_match, the saturating match_count and
// stream_done echoing text_end on text items (low for other items).
// Load, clear and unused items pass from acceptance to the finish state and then
// to the result register. A text item, L the clamped pattern length, scans the
// L pattern store entries through its single read port to compare them with
// the symbol, drains, then reads and updates each rotation's progress row in
// the progress memory before it finishes.
// Input is taken only between items; a finished result waits in the output
// register while the next item is accepted and worked on, and the block holds
// at its finish step while the receiver stalls with a result still pending.
// Reset (rst_n low, synchronous) clears count, progress, load pointer and
// sets the length to 1; the pattern store is undefined until loaded.
module rotation_window_match_counter #(
  parameter int unsigned MAX_PATTERN = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  rwm_in_if.sink                    in_ch,
  rwm_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [rwm_pkg::CFG_W-1:0] cfg_wdata
);

  rwm_pkg::ctrl_cmd_t cmd;
  rwm_pkg::dp_stat_t  stat;
  logic               in_ready;

  assign in_ch.ready = in_ready;

  rwm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rwm_dp #(.MAX_PATTERN(MAX_PATTERN)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_command       (in_ch.command),
    .in_symbol        (in_ch.symbol),
    .in_text_end      (in_ch.text_end),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_window_match (out_ch.window_match),
    .out_match_count  (out_ch.match_count),
    .out_stream_done  (out_ch.stream_done)
  );

endmodule

// ----- rtl/core/rwm_chk.sv -----
// Port checker for the rotation window match counter, bound to the top level.
// Depends on rwm_pkg for field widths.
module rwm_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_window_match,
  input logic [rwm_pkg::COUNT_W-1:0] out_match_count
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_match_count))
    else $error("result dropped or changed under stall");

  // a matching window is always counted
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_window_match |-> out_match_count != '0)
    else $error("match reported with zero count");

  // no result item straight after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // no new item is taken in the cycle after one is accepted
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

endmodule

bind rotation_window_match_counter rwm_chk u_rwm_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_window_match (out_ch.window_match),
  .out_match_count  (out_ch.match_count)
);

// ----- tb/rwm_tb_ifs.sv -----
// Testbench-side view of the channel interfaces for the rotation window match counter.
// The interfaces themselves come from the RTL file rwm_ifs.sv; this file only holds a
// small package of testbench types. Depends on rwm_pkg.
package rwm_tb_pkg;

  // one expected result item
  typedef struct packed {
    logic                        window_match;
    logic [rwm_pkg::COUNT_W-1:0] match_count;
    logic                        stream_done;
  } match_result_t;
endpackage

// ----- tb/tb_rotation_window_match_counter.sv -----
// Testbench for the rotation window match counter: directed and random items with
// random idling on both channels, checked against a cycle-free rotation matcher.
// Depends on rwm_pkg, rwm_ifs, rwm_tb_pkg and the block's RTL.
module tb_rotation_window_match_counter;

  localparam int MAXP = 64;
  localparam int CYCLE_LIMIT = 900000;

  // scoreboard: rotation matcher plus queue of pending results
  class match_scoreboard;
    logic [7:0]  pat [MAXP];
    int          load_ptr;
    logic [63:0] progress [MAXP];
    logic [31:0] total;
    int          plen;
    rwm_tb_pkg::match_result_t pending [$];
    int          errors;

    function void reset_state();
      for (int i = 0; i < MAXP; i++) begin
        pat[i] = '0;
        progress[i] = '0;
      end
      load_ptr = 0;
      total = '0;
      plen = 1;
      errors = 0;
    endfunction

    function void set_length(logic [6:0] v);
      plen = (v == 0) ? 1 : ((v > MAXP) ? MAXP : v);
    endfunction

    // work out the result of one accepted item
    function void note_item(rwm_pkg::cmd_t cmd, logic [7:0] sym, logic tend);
      rwm_tb_pkg::match_result_t res;
      logic [63:0] eq, lmask, top;
      logic hit;
      int idx;
      res = '0;
      if (cmd == rwm_pkg::CMD_LOAD) begin
        if (load_ptr < MAXP) begin
          pat[load_ptr] = sym;
          load_ptr++;
        end
      end else if (cmd == rwm_pkg::CMD_TEXT) begin
        lmask = (plen >= 64) ? '1 : ((64'd1 << plen) - 1);
        top = 64'd1 << (plen - 1);
        hit = 1'b0;
        for (int r = 0; r < MAXP; r++) begin
          if (r >= plen) begin
            progress[r] = '0;
          end else begin
            eq = '0;
            for (int k = 0; k < plen; k++) begin
              idx = r + k;
              if (idx >= plen) idx -= plen;
              if (pat[idx] == sym) eq[k] = 1'b1;
            end
            progress[r] = ((progress[r] << 1) | 64'd1) & eq & lmask;
            if ((progress[r] & top) != 0) hit = 1'b1;
          end
        end
        if (hit && total != '1) total++;
        res.window_match = hit;
        res.stream_done = tend;
      end else if (cmd == rwm_pkg::CMD_CLEAR) begin
        for (int i = 0; i < MAXP; i++) progress[i] = '0;
        load_ptr = 0;
        total = '0;
      end
      res.match_count = total;
      pending.push_back(res);
    endfunction

    function void check_result(rwm_tb_pkg::match_result_t got);
      rwm_tb_pkg::match_result_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.window_match !== exp.window_match) begin
        $display("%0t: window_match exp %b got %b", $time, exp.window_match,
                 got.window_match);
        errors++;
      end
      if (got.match_count !== exp.match_count) begin
        $display("%0t: match_count exp %0d got %0d", $time, exp.match_count,
                 got.match_count);
        errors++;
      end
      if (got.stream_done !== exp.stream_done) begin
        $display("%0t: stream_done exp %b got %b", $time, exp.stream_done,
                 got.stream_done);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [rwm_pkg::CFG_W-1:0] cfg_wdata = '0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int cycles = 0;
  match_scoreboard sb;

  rwm_in_if  in_ch ();
  rwm_out_if out_ch ();

  rotation_window_match_counter dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = '0;
    in_ch.symbol = '0;
    in_ch.text_end = 1'b0;
    out_ch.ready = 1'b0;
  end

  // timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result checking at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.window_match, out_ch.match_count, out_ch.stream_done});
  end

  // receiver ready, changed at the falling edge
  always @(negedge clk) begin
    if (hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // one item, with random leading idle cycles; valid is left to the next caller
  task automatic send_item(rwm_pkg::cmd_t cmd, logic [7:0] sym, logic tend);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.symbol <= sym;
    in_ch.text_end <= tend;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_item(cmd, sym, tend);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (3 * MAXP + 10) @(negedge clk);
  endtask

  task automatic write_length(logic [6:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_length(v);
  endtask

  // full pattern load after a clear, so no unwritten entry is ever compared
  task automatic load_pattern(int n, int alpha);
    send_item(rwm_pkg::CMD_CLEAR, 8'($urandom), 1'($urandom));
    for (int i = 0; i < n; i++)
      send_item(rwm_pkg::CMD_LOAD, 8'($urandom_range(alpha - 1)), 1'($urandom));
  endtask

  // a text run mostly built from rotations of the stored pattern
  task automatic text_run(int n, int len, int alpha);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(len - 1);
      if ($urandom_range(3) != 0 && len > 0) begin
        for (int k = 0; k < len && i < n; k++, i++)
          send_item(rwm_pkg::CMD_TEXT, sb.pat[(r + k) % len], $urandom_range(15) == 0);
        i--;
      end else begin
        send_item(rwm_pkg::CMD_TEXT, 8'($urandom_range(alpha - 1)),
                  $urandom_range(15) == 0);
      end
    end
  endtask

  initial begin
    int lens [6] = '{1, 2, 3, 5, 64, 4};
    int len, alpha;
    sb = new();
    sb.reset_state();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: length 1, byte extremes, all commands, overflow, odd lengths
    write_length(7'd1);
    send_item(rwm_pkg::CMD_LOAD, 8'hFF, 1'b1);
    send_item(rwm_pkg::CMD_TEXT, 8'hFF, 1'b0);
    send_item(rwm_pkg::CMD_TEXT, 8'h00, 1'b1);
    send_item(rwm_pkg::CMD_TEXT, 8'hFF, 1'b1);
    send_item(rwm_pkg::cmd_t'(2'd3), 8'hAA, 1'b1);
    send_item(rwm_pkg::CMD_LOAD, 8'h00, 1'b0);
    send_item(rwm_pkg::CMD_TEXT, 8'hFF, 1'b0);
    send_item(rwm_pkg::CMD_CLEAR, 8'h55, 1'b1);
    send_item(rwm_pkg::CMD_LOAD, 8'h00, 1'b0);
    send_item(rwm_pkg::CMD_TEXT, 8'h00, 1'b1);
    write_length(7'd0);
    send_item(rwm_pkg::CMD_TEXT, 8'h00, 1'b0);
    write_length(7'd3);
    send_item(rwm_pkg::CMD_CLEAR, 8'h00, 1'b0);
    send_item(rwm_pkg::CMD_LOAD, 8'h01, 1'b0);
    send_item(rwm_pkg::CMD_LOAD, 8'h02, 1'b0);
    send_item(rwm_pkg::CMD_LOAD, 8'h03, 1'b0);
    send_item(rwm_pkg::CMD_TEXT, 8'h02, 1'b0);
    send_item(rwm_pkg::CMD_TEXT, 8'h03, 1'b0);
    send_item(rwm_pkg::CMD_TEXT, 8'h01, 1'b1);
    send_item(rwm_pkg::CMD_TEXT, 8'h02, 1'b0);
    // lengths above the maximum act as the maximum; overflow loads are ignored
    write_length(7'd127);
    load_pattern(66, 2);
    text_run(8, 64, 2);

    // random phases with changing idling and lengths
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      len = lens[ph % 6];
      alpha = (ph % 3 == 0) ? 256 : 3;
      write_length(len[6:0]);
      load_pattern(len, alpha);
      if (ph == 2) begin
        // receiver holds off for a long stretch while items keep coming
        fork
          begin
            hold_off = 1'b1;
            repeat (400) @(negedge clk);
            hold_off = 1'b0;
          end
          text_run(6, len, alpha);
        join
      end
      text_run((len == 64) ? 12 : 30, len, alpha);
      if ($urandom_range(1))
        send_item(rwm_pkg::cmd_t'($urandom_range(3)), 8'($urandom), 1'($urandom));
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/core/rwm_pkg.sv
rtl/core/rwm_ifs.sv
rtl/core/rwm_ctrl.sv
rtl/core/rwm_dp.sv
rtl/core/rotation_window_match_counter.sv
rtl/core/rwm_chk.sv
tb/rwm_tb_ifs.sv
tb/tb_rotation_window_match_counter.sv
